[design/three_channel_health_alarm_defines.svh]
// Assertion macros used by the health alarm checker.
`ifndef THREE_CHANNEL_HEALTH_ALARM_DEFINES_SVH
`define THREE_CHANNEL_HEALTH_ALARM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tcha_pkg.sv]
// Package with the codes and constants of the three channel health alarm.
package tcha_pkg;

    localparam int READING_WIDTH = 16;
    localparam int COUNT_WIDTH = 8;
    localparam int OP_WIDTH = 3;
    localparam int MODE_WIDTH = 2;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_CHANNELS = 3;
    localparam int CH_WIDTH = 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 8'd4;
    localparam logic [31:0] LIMIT_RESET = 32'h0000_7FFF;

    localparam logic [OP_WIDTH-1:0] OP_START = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_STOP = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_TICK = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_SPEED = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_INCLINE = 3'd4;
    localparam logic [OP_WIDTH-1:0] OP_PULSE = 3'd5;

    localparam logic [MODE_WIDTH-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_ACTIVE = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_EMERGENCY = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INCLINE_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRIP_COUNT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLEAR_COUNT = 3'd4;

endpackage

[design/three_channel_health_alarm.sv]
// Three channel health alarm: speed, incline and pulse qualification with trip and clear counts.
// Result: an accepted transaction's result is written to the output register and shown in the next cycle.
// Throughput: one transaction per cycle unless stalled; the mode and counter update is a
// single compare and a small decrement, settling between input handshake and result register.
// Reset: mode stopped, stored readings zero, over countdowns at 4, under countdowns zero, limits
// at 32767 (truncated to the reading width), trip and clear counts at 4, no result pending.
module three_channel_health_alarm #(
    parameter int READING_WIDTH = tcha_pkg::READING_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Item input channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tcha_pkg::OP_WIDTH-1:0]        operation,
    input  logic signed [READING_WIDTH-1:0]      reading,
    // Result output channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tcha_pkg::MODE_WIDTH-1:0]      mode,
    output logic                                 report_valid,
    output logic signed [READING_WIDTH-1:0]      speed_report,
    output logic signed [READING_WIDTH-1:0]      incline_report,
    output logic signed [READING_WIDTH-1:0]      pulse_report,
    output logic                                 alarm_raised,
    output logic                                 alarm_cleared,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcha_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [READING_WIDTH-1:0]             cfg_data
);

    localparam int CW = tcha_pkg::COUNT_WIDTH;
    localparam int NCH = tcha_pkg::NUM_CHANNELS;
    localparam logic [READING_WIDTH-1:0] LIMIT_RST = READING_WIDTH'(tcha_pkg::LIMIT_RESET);

    // Configuration registers; always ready. Write only while idle (the block does not check).
    logic [READING_WIDTH-1:0] limit_reg [NCH];
    logic [CW-1:0]            trip_count_reg;
    logic [CW-1:0]            clear_count_reg;

    // Block state.
    logic [tcha_pkg::MODE_WIDTH-1:0] mode_reg, mode_next;
    logic [READING_WIDTH-1:0]        last_reg [NCH];
    logic [READING_WIDTH-1:0]        last_next [NCH];
    logic [CW-1:0]                   over_reg [NCH];
    logic [CW-1:0]                   over_next [NCH];
    logic [CW-1:0]                   under_reg [NCH];
    logic [CW-1:0]                   under_next [NCH];

    // Result register.
    logic                            out_valid_reg, out_valid_next;
    logic [tcha_pkg::MODE_WIDTH-1:0] res_mode_reg;
    logic                            res_report_reg;
    logic                            res_raised_reg;
    logic                            res_cleared_reg;
    logic [READING_WIDTH-1:0]        res_last_reg [NCH];

    logic                          in_accept;
    logic                          is_reading;
    logic [tcha_pkg::CH_WIDTH-1:0] ch;
    logic                          over;
    logic                          report_next;
    logic                          raised_next;
    logic                          cleared_next;

    // The single result register frees up whenever its transaction is taken, so a new item is
    // accepted in the same cycle the previous result leaves.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                limit_reg[i] <= LIMIT_RST;
            end
            trip_count_reg  <= tcha_pkg::COUNT_RESET;
            clear_count_reg <= tcha_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcha_pkg::CFG_SPEED_LIMIT:   limit_reg[0] <= cfg_data;
                tcha_pkg::CFG_INCLINE_LIMIT: limit_reg[1] <= cfg_data;
                tcha_pkg::CFG_PULSE_LIMIT:   limit_reg[2] <= cfg_data;
                tcha_pkg::CFG_TRIP_COUNT:    trip_count_reg <= cfg_data[CW-1:0];
                tcha_pkg::CFG_CLEAR_COUNT:   clear_count_reg <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Reading operations map onto channel 0, 1 and 2 in operation code order.
    assign is_reading = (operation == tcha_pkg::OP_SPEED) ||
                        (operation == tcha_pkg::OP_INCLINE) ||
                        (operation == tcha_pkg::OP_PULSE);
    assign ch = tcha_pkg::CH_WIDTH'(operation - tcha_pkg::OP_SPEED);
    assign over = is_reading && (reading >= $signed(limit_reg[ch]));

    always_comb
    begin
        mode_next    = mode_reg;
        last_next    = last_reg;
        over_next    = over_reg;
        under_next   = under_reg;
        report_next  = 1'b0;
        raised_next  = 1'b0;
        cleared_next = 1'b0;

        if (in_accept)
        begin
            if (mode_reg == tcha_pkg::MODE_STOPPED)
            begin
                // While stopped only a motion start has any effect.
                if (operation == tcha_pkg::OP_START)
                begin
                    mode_next = tcha_pkg::MODE_ACTIVE;
                end
            end
            else if (operation == tcha_pkg::OP_STOP)
            begin
                // Counters are kept across a stop.
                mode_next = tcha_pkg::MODE_STOPPED;
            end
            else if (operation == tcha_pkg::OP_TICK)
            begin
                report_next = 1'b1;
            end
            else if (is_reading)
            begin
                last_next[ch] = reading;
                if (mode_reg == tcha_pkg::MODE_ACTIVE)
                begin
                    if (over)
                    begin
                        if (over_reg[ch] != '0)
                        begin
                            over_next[ch] = over_reg[ch] - 1'b1;
                        end
                        else
                        begin
                            mode_next      = tcha_pkg::MODE_EMERGENCY;
                            raised_next    = 1'b1;
                            under_next[ch] = clear_count_reg;
                        end
                    end
                    else
                    begin
                        over_next[ch] = trip_count_reg;
                    end
                end
                else
                begin
                    if (!over)
                    begin
                        if (under_reg[ch] != '0)
                        begin
                            under_next[ch] = under_reg[ch] - 1'b1;
                        end
                    end
                    else
                    begin
                        under_next[ch] = clear_count_reg;
                    end
                    // The emergency ends once every channel has run its under count down.
                    if ((under_next[0] == '0) && (under_next[1] == '0) &&
                        (under_next[2] == '0))
                    begin
                        mode_next    = tcha_pkg::MODE_ACTIVE;
                        cleared_next = 1'b1;
                        for (int i = 0; i < NCH; i++)
                        begin
                            over_next[i]  = trip_count_reg;
                            under_next[i] = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tcha_pkg::MODE_STOPPED;
            for (int i = 0; i < NCH; i++)
            begin
                last_reg[i]  <= '0;
                over_reg[i]  <= tcha_pkg::COUNT_RESET;
                under_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg  <= mode_next;
            last_reg  <= last_next;
            over_reg  <= over_next;
            under_reg <= under_next;
        end
    end

    // Result valid: set by an accepted item, dropped once the waiting transaction is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload holds while stalled, since nothing is accepted then.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_mode_reg    <= mode_next;
            res_report_reg  <= report_next;
            res_raised_reg  <= raised_next;
            res_cleared_reg <= cleared_next;
            res_last_reg    <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode           = res_mode_reg;
    assign report_valid   = res_report_reg;
    assign alarm_raised   = res_raised_reg;
    assign alarm_cleared  = res_cleared_reg;
    assign speed_report   = $signed(res_last_reg[0]);
    assign incline_report = $signed(res_last_reg[1]);
    assign pulse_report   = $signed(res_last_reg[2]);

endmodule

[design/tcha_checker.sv]
// Port-level checker for the three channel health alarm and its bind statement.
`include "three_channel_health_alarm_defines.svh"

module tcha_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [tcha_pkg::MODE_WIDTH-1:0] mode,
    input logic                            report_valid,
    input logic                            alarm_raised,
    input logic                            alarm_cleared
);

    // A stalled result transaction stays offered.
    `TCHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "result dropped while stalled")

    // A trip always lands in emergency mode.
    `TCHA_ASSERT_NOW(a_raise_mode, clk, rst_n, out_valid && alarm_raised,
        mode == tcha_pkg::MODE_EMERGENCY, "alarm raised outside emergency")

    // Ending an emergency always returns to active mode.
    `TCHA_ASSERT_NOW(a_clear_mode, clk, rst_n, out_valid && alarm_cleared,
        mode == tcha_pkg::MODE_ACTIVE, "alarm cleared outside active")

    // Reports come only from ticks, never alongside an alarm event or while stopped.
    `TCHA_ASSERT_NOW(a_report_excl, clk, rst_n, out_valid && report_valid,
        !alarm_raised && !alarm_cleared && (mode != tcha_pkg::MODE_STOPPED),
        "report with alarm event or stopped")

endmodule

bind three_channel_health_alarm tcha_checker u_tcha_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mode(mode),
    .report_valid(report_valid),
    .alarm_raised(alarm_raised),
    .alarm_cleared(alarm_cleared)
);

[tb/sv/tb.sv]
// Self-checking testbench for the three channel health alarm, with its own mode and counter predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RW = tcha_pkg::READING_WIDTH;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    // The limit leaves a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT = 200000;
    // A result shows up in the cycle after its transaction; the spare cycles here cover it.
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_PRINTED = 40;

    localparam int READING_MAX_I = (1 << (RW - 1)) - 1;
    localparam int READING_MIN_I = -(1 << (RW - 1));
    localparam logic signed [RW-1:0] READING_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic signed [RW-1:0] READING_MIN = {1'b1, {(RW-1){1'b0}}};

    // Operation codes and register indexes that the block has no use for.
    localparam logic [tcha_pkg::OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [tcha_pkg::OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;
    localparam int CFG_INDEX_TOP = (1 << tcha_pkg::CFG_INDEX_WIDTH) - 1;

    // One result transaction, field for field as the block presents it.
    typedef struct packed {
        logic [tcha_pkg::MODE_WIDTH-1:0] mode;
        logic                            report_valid;
        logic signed [RW-1:0]            speed_report;
        logic signed [RW-1:0]            incline_report;
        logic signed [RW-1:0]            pulse_report;
        logic                            alarm_raised;
        logic                            alarm_cleared;
    } alarm_result_t;

    // The scoreboard keeps its own copy of the mode, the stored readings, both sets of
    // countdowns and the register file, and queues the result each transaction must give.
    class alarm_scoreboard;
        logic signed [RW-1:0]             limit_q[3];
        logic [tcha_pkg::COUNT_WIDTH-1:0] trip_q;
        logic [tcha_pkg::COUNT_WIDTH-1:0] clear_q;
        logic [tcha_pkg::MODE_WIDTH-1:0]  mode_q;
        logic signed [RW-1:0]             stored[3];
        logic [tcha_pkg::COUNT_WIDTH-1:0] over_left[3];
        logic [tcha_pkg::COUNT_WIDTH-1:0] under_left[3];
        alarm_result_t                    predicted_results[$];
        int                               errors;
        int                               results_seen;

        function new();
            errors = 0;
            results_seen = 0;
            trip_q = tcha_pkg::COUNT_RESET;
            clear_q = tcha_pkg::COUNT_RESET;
            mode_q = tcha_pkg::MODE_STOPPED;
            for (int i = 0; i < 3; i++) begin
                limit_q[i] = tcha_pkg::LIMIT_RESET[RW-1:0];
                stored[i] = '0;
                over_left[i] = tcha_pkg::COUNT_RESET;
                under_left[i] = '0;
            end
        endfunction

        function void apply_register(logic [tcha_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                     logic [RW-1:0] data);
            case (idx)
                tcha_pkg::CFG_SPEED_LIMIT:   limit_q[0] = data;
                tcha_pkg::CFG_INCLINE_LIMIT: limit_q[1] = data;
                tcha_pkg::CFG_PULSE_LIMIT:   limit_q[2] = data;
                tcha_pkg::CFG_TRIP_COUNT:    trip_q = data[tcha_pkg::COUNT_WIDTH-1:0];
                tcha_pkg::CFG_CLEAR_COUNT:   clear_q = data[tcha_pkg::COUNT_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // Advances the predicted state by one accepted transaction and queues its result.
        function void track_item(logic [tcha_pkg::OP_WIDTH-1:0] op, logic signed [RW-1:0] rd);
            alarm_result_t r;
            int ch;
            logic over;
            r = '0;
            if (mode_q == tcha_pkg::MODE_STOPPED) begin
                if (op == tcha_pkg::OP_START)
                    mode_q = tcha_pkg::MODE_ACTIVE;
            end else if (op == tcha_pkg::OP_STOP) begin
                mode_q = tcha_pkg::MODE_STOPPED;
            end else if (op == tcha_pkg::OP_TICK) begin
                r.report_valid = 1'b1;
            end else if (op >= tcha_pkg::OP_SPEED && op <= tcha_pkg::OP_PULSE) begin
                ch = int'(op - tcha_pkg::OP_SPEED);
                over = (rd >= limit_q[ch]);
                stored[ch] = rd;
                if (mode_q == tcha_pkg::MODE_ACTIVE) begin
                    if (!over) begin
                        over_left[ch] = trip_q;
                    end else if (over_left[ch] != 0) begin
                        over_left[ch] = over_left[ch] - 1'b1;
                    end else begin
                        mode_q = tcha_pkg::MODE_EMERGENCY;
                        r.alarm_raised = 1'b1;
                        under_left[ch] = clear_q;
                    end
                end else begin
                    if (over)
                        under_left[ch] = clear_q;
                    else if (under_left[ch] != 0)
                        under_left[ch] = under_left[ch] - 1'b1;
                    // All three channels are looked at after every reading in an emergency.
                    if (under_left[0] == 0 && under_left[1] == 0 && under_left[2] == 0) begin
                        mode_q = tcha_pkg::MODE_ACTIVE;
                        r.alarm_cleared = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            over_left[i] = trip_q;
                            under_left[i] = '0;
                        end
                    end
                end
            end
            r.mode = mode_q;
            r.speed_report = stored[0];
            r.incline_report = stored[1];
            r.pulse_report = stored[2];
            predicted_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        endtask

        task check_result(alarm_result_t got);
            alarm_result_t want;
            results_seen++;
            if (predicted_results.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
                return;
            end
            want = predicted_results.pop_front();
            if (got.mode !== want.mode)
                report_mismatch($sformatf("mode %0d, expected %0d", got.mode, want.mode));
            if (got.report_valid !== want.report_valid)
                report_mismatch($sformatf("report_valid %0b, expected %0b",
                                          got.report_valid, want.report_valid));
            if (got.speed_report !== want.speed_report)
                report_mismatch($sformatf("speed_report %0d, expected %0d",
                                          got.speed_report, want.speed_report));
            if (got.incline_report !== want.incline_report)
                report_mismatch($sformatf("incline_report %0d, expected %0d",
                                          got.incline_report, want.incline_report));
            if (got.pulse_report !== want.pulse_report)
                report_mismatch($sformatf("pulse_report %0d, expected %0d",
                                          got.pulse_report, want.pulse_report));
            if (got.alarm_raised !== want.alarm_raised)
                report_mismatch($sformatf("alarm_raised %0b, expected %0b",
                                          got.alarm_raised, want.alarm_raised));
            if (got.alarm_cleared !== want.alarm_cleared)
                report_mismatch($sformatf("alarm_cleared %0b, expected %0b",
                                          got.alarm_cleared, want.alarm_cleared));
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [tcha_pkg::OP_WIDTH-1:0]        operation = '0;
    logic signed [RW-1:0]                 reading = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [tcha_pkg::MODE_WIDTH-1:0]      mode;
    logic                                 report_valid;
    logic signed [RW-1:0]                 speed_report;
    logic signed [RW-1:0]                 incline_report;
    logic signed [RW-1:0]                 pulse_report;
    logic                                 alarm_raised;
    logic                                 alarm_cleared;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [tcha_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [RW-1:0]                        cfg_data = '0;

    alarm_scoreboard sb = new();
    int cycle_count = 0;
    int hot_channel = 0;

    three_channel_health_alarm #(.READING_WIDTH(RW)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .reading(reading),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mode(mode),
        .report_valid(report_valid),
        .speed_report(speed_report),
        .incline_report(incline_report),
        .pulse_report(pulse_report),
        .alarm_raised(alarm_raised),
        .alarm_cleared(alarm_cleared),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a run that hangs or crawls ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // All handshakes are observed at the rising edge, where every input driven at the falling
    // edge is stable. The result check comes before the input is noted; since the block
    // registers its result, a transaction accepted at this edge cannot be the one shown now.
    always @(posedge clk)
    begin
        alarm_result_t got;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got.mode = mode;
                got.report_valid = report_valid;
                got.speed_report = speed_report;
                got.incline_report = incline_report;
                got.pulse_report = pulse_report;
                got.alarm_raised = alarm_raised;
                got.alarm_cleared = alarm_cleared;
                sb.check_result(got);
            end
            if (in_valid && !in_stall)
                sb.track_item(operation, reading);
            if (cfg_valid && cfg_ready)
                sb.apply_register(cfg_index, cfg_data);
        end
    end

    // The result side stalls by a pattern of its own: it switches between no stalls, sparse
    // and dense random stalls, a fixed period and long on/off runs, picked anew for each segment.
    int stall_style = 0;
    int stall_seg_left = 0;
    int stall_run_left = 0;
    logic stall_run_on = 1'b0;

    always @(negedge clk)
    begin
        if (stall_seg_left == 0) begin
            stall_style = $urandom_range(0, 4);
            stall_seg_left = $urandom_range(50, 300);
        end
        stall_seg_left--;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 70);
            3: out_stall <= ((stall_seg_left % 5) < 2);
            default:
            begin
                if (stall_run_left == 0) begin
                    stall_run_left = $urandom_range(1, 12);
                    stall_run_on = ~stall_run_on;
                end
                stall_run_left--;
                out_stall <= stall_run_on;
            end
        endcase
    end

    // Presents one transaction and holds it until the block takes it. Valid stays high
    // when the next call follows straight away, which gives back-to-back transactions.
    task send_item(input logic [tcha_pkg::OP_WIDTH-1:0] op, input logic signed [RW-1:0] rd);
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        reading <= rd;
        do @(posedge clk); while (in_stall);
    endtask

    // Drops valid for a stretch set by n; the payload carries noise the block must not act on.
    task hold_off(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        operation <= tcha_pkg::OP_WIDTH'($urandom);
        reading <= RW'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task cfg_write(input int idx, input logic [RW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= tcha_pkg::CFG_INDEX_WIDTH'(idx);
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops the input stream and waits for every pending result, then for a spare stretch set by DRAIN_CYCLES.
    task settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Picks a reading on the requested side of the channel limit. Now and then it hits the
    // limit itself or the value just under it, or, when noise is allowed, anything at all.
    function automatic logic signed [RW-1:0] pick_reading(int ch, bit want_over, bit noisy);
        int lim;
        int r;
        lim = int'(sb.limit_q[ch]);
        r = $urandom_range(0, 99);
        if (noisy && r < 8)
            return RW'($urandom);
        if (want_over || lim == READING_MIN_I) begin
            if (r < 16)
                return RW'(lim);
            return RW'(lim + int'($urandom_range(0, READING_MAX_I - lim)));
        end
        if (r < 16)
            return RW'(lim - 1);
        return RW'(lim - 1 - int'($urandom_range(0, lim - 1 - READING_MIN_I)));
    endfunction

    // Chooses the next transaction from the predicted mode. While stopped it mostly starts;
    // while active it leans toward over readings so that trips happen; in an emergency it
    // leans toward under readings so that the clear count is worked through.
    task next_item(output logic [tcha_pkg::OP_WIDTH-1:0] op, output logic signed [RW-1:0] rd);
        int r;
        int ch;
        bit want_over;
        r = $urandom_range(0, 99);
        rd = RW'($urandom);
        if (sb.mode_q == tcha_pkg::MODE_STOPPED) begin
            op = (r < 60) ? tcha_pkg::OP_START : tcha_pkg::OP_WIDTH'($urandom_range(0, 7));
        end else if (r < 3) begin
            op = tcha_pkg::OP_STOP;
        end else if (r < 11) begin
            op = tcha_pkg::OP_TICK;
        end else if (r < 14) begin
            case ($urandom_range(0, 2))
                0: op = tcha_pkg::OP_START;
                1: op = OP_SPARE_LO;
                default: op = OP_SPARE_HI;
            endcase
        end else begin
            ch = ($urandom_range(0, 99) < 60) ? hot_channel : int'($urandom_range(0, 2));
            op = tcha_pkg::OP_SPEED + tcha_pkg::OP_WIDTH'(ch);
            if (sb.mode_q == tcha_pkg::MODE_ACTIVE)
                want_over = ($urandom_range(0, 99) < 70);
            else
                want_over = ($urandom_range(0, 99) < 12);
            rd = pick_reading(ch, want_over, 1'b1);
        end
    endtask

    // Random traffic in bursts; with gaps off the stream runs without any idle cycle.
    task run_random(input int n, input bit gaps);
        int burst_left;
        logic [tcha_pkg::OP_WIDTH-1:0] op;
        logic signed [RW-1:0] rd;
        burst_left = 0;
        repeat (n) begin
            if (burst_left == 0) begin
                if (gaps && $urandom_range(0, 99) < 50)
                    hold_off($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
                hot_channel = $urandom_range(0, 2);
            end
            burst_left--;
            next_item(op, rd);
            send_item(op, rd);
        end
    endtask

    // Count registers get random upper bits in the data word; only the low byte is kept.
    task load_settings(input logic [RW-1:0] speed_lim, input logic [RW-1:0] incline_lim,
                       input logic [RW-1:0] pulse_lim, input int trip, input int clear);
        logic [RW-1:0] word;
        cfg_write(tcha_pkg::CFG_SPEED_LIMIT, speed_lim);
        cfg_write(tcha_pkg::CFG_INCLINE_LIMIT, incline_lim);
        cfg_write(tcha_pkg::CFG_PULSE_LIMIT, pulse_lim);
        word = RW'($urandom);
        word[tcha_pkg::COUNT_WIDTH-1:0] = tcha_pkg::COUNT_WIDTH'(trip);
        cfg_write(tcha_pkg::CFG_TRIP_COUNT, word);
        word = RW'($urandom);
        word[tcha_pkg::COUNT_WIDTH-1:0] = tcha_pkg::COUNT_WIDTH'(clear);
        cfg_write(tcha_pkg::CFG_CLEAR_COUNT, word);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset settings (limits at the top value, both counts at 4).
        // In the stopped mode, ticks, readings, stops and spare codes all do nothing.
        send_item(tcha_pkg::OP_TICK, '0);
        send_item(tcha_pkg::OP_SPEED, READING_MAX);
        send_item(OP_SPARE_LO, READING_MIN);
        send_item(tcha_pkg::OP_STOP, '0);
        // Start enters the active mode; a second start is ignored.
        send_item(tcha_pkg::OP_START, '0);
        send_item(tcha_pkg::OP_START, READING_MAX);
        send_item(OP_SPARE_HI, '1);
        // A tick reports the stored readings, which are still zero.
        send_item(tcha_pkg::OP_TICK, '0);
        send_item(tcha_pkg::OP_INCLINE, READING_MIN);
        // A reading equal to the limit counts as over: the fifth one in a row trips.
        repeat (5) send_item(tcha_pkg::OP_SPEED, READING_MAX);
        send_item(tcha_pkg::OP_TICK, '0);
        send_item(tcha_pkg::OP_PULSE, '0);
        // Stop leaves the emergency but keeps every countdown, so after a restart the speed
        // channel, whose over countdown is still at zero, trips on its very next over reading.
        send_item(tcha_pkg::OP_STOP, '0);
        send_item(tcha_pkg::OP_START, '0);
        send_item(tcha_pkg::OP_SPEED, READING_MAX);
        // Four under readings on speed bring its under countdown to zero and end the emergency.
        repeat (4) send_item(tcha_pkg::OP_SPEED, READING_MIN);
        send_item(tcha_pkg::OP_TICK, '0);
        settle();

        // Mid-range limits with short counts.
        load_settings('0, '0, '0, 2, 3);
        run_random(150, 1'b1);
        settle();

        // Extreme limits and both counts at zero: a trip loads a zero under countdown, so the
        // first reading in the emergency can end it at once.
        load_settings(READING_MIN, READING_MAX, RW'($urandom), 0, 0);
        run_random(150, 1'b1);
        settle();

        // Largest trip count: 256 over readings in a row on one channel, after an under
        // reading has reloaded its countdown, are needed for the trip.
        load_settings(RW'(1000), RW'($urandom), RW'($urandom), 255, 1);
        send_item(tcha_pkg::OP_STOP, '0);
        send_item(tcha_pkg::OP_START, '0);
        send_item(tcha_pkg::OP_SPEED, pick_reading(0, 1'b0, 1'b0));
        repeat (256) send_item(tcha_pkg::OP_SPEED, pick_reading(0, 1'b1, 1'b0));
        run_random(100, 1'b1);
        settle();

        // Largest clear count, with the input stream running flat out.
        load_settings(RW'($urandom), RW'($urandom), RW'($urandom), 1, 255);
        run_random(150, 1'b0);
        settle();

        load_settings(READING_MAX, READING_MAX, READING_MAX, 3, 2);
        run_random(120, 1'b1);
        settle();

        // Random settings; writes to unused register indexes must leave everything alone.
        repeat (2) begin
            load_settings(RW'($urandom), RW'($urandom), RW'($urandom), $urandom_range(0, 6),
                          $urandom_range(0, 6));
            cfg_write($urandom_range(tcha_pkg::CFG_CLEAR_COUNT + 1, CFG_INDEX_TOP),
                      RW'($urandom));
            run_random(150, 1'b1);
            settle();
        end

        if (sb.errors == 0 && sb.predicted_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/tcha_pkg.sv
design/three_channel_health_alarm.sv
design/tcha_checker.sv
tb/sv/tb.sv
